/* rtl/tgad_pkg.sv */
// Shared constants and types of the trace group average decimator.
package tgad_pkg;

   // Default sizes handed to the top level.
   localparam int MAX_ROWS_DEFAULT = 1024;
   localparam int MAX_STEP_DEFAULT = 16;

   // Fixed field widths.
   localparam int SAMPLE_W   = 32;
   localparam int ROWS_CFG_W = 11;
   localparam int STEP_CFG_W = 5;

   // CSR port.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_LSB = 2;

   // Register indexes (paddr bit CSR_IDX_LSB).
   localparam logic REG_ROWS_PER_TRACE = 1'b0;
   localparam logic REG_GROUP_STEP     = 1'b1;

   // Register reset values.
   localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(1);
   localparam logic [STEP_CFG_W-1:0] STEP_RESET = STEP_CFG_W'(2);

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_HOLD
   } state_type;

endpackage

/* rtl/tgad_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module tgad_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tgad_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero.
module tgad_div #(
   parameter int SUM_W = 36,
   parameter int DIV_W = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [SUM_W-1:0]           dividend,
   input  logic [DIV_W-1:0]                  divisor,
   output logic                              done,
   output logic signed [tgad_pkg::SAMPLE_W-1:0] quotient
);
   import tgad_pkg::*;

   localparam int IT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [IT_W-1:0]  iter_ff, iter_in;
   logic [SUM_W-1:0] mag_ff, mag_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic             neg_ff, neg_in;

   logic [DIV_W:0]   trial;
   logic             qbit;
   logic [SUM_W-1:0] quo_signed;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, mag_ff[SUM_W-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      if (start) begin
         busy_in = 1'b1;
         iter_in = IT_W'(SUM_W - 1);
         mag_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         // restoring step: shift a dividend bit in, subtract if it fits
         rem_in = qbit ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         mag_in = {mag_ff[SUM_W-2:0], qbit};
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            iter_in = iter_ff - IT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // quotient magnitude never exceeds 2^31, so the low word is exact
   assign quo_signed = neg_ff ? (~mag_ff + SUM_W'(1)) : mag_ff;
   assign quotient   = quo_signed[SAMPLE_W-1:0];
   assign done       = done_ff;

endmodule

/* rtl/trace_group_average_decimator.sv */
// Top level of the trace group average decimator: sequencer, CSRs, row-sum RAM, divider.
//
//   channel | dir | handshake                       | word
//   --------+-----+---------------------------------+------------------------------------
//   req     | in  | req_valid / req_ready           | sample, block_end
//   rsp     | out | rsp_valid / rsp_ready           | average, row_index, last_row
//   csr     | in  | psel / penable / pwrite, pready | rows_per_trace @0x0, group_step @0x4
//
// A word that closes no group passes through IDLE, where its row sum is read from the
// RAM (registered read), and READ, where the sample is added and the sum written back.
// A word that closes a group then waits in DIV (and in HOLD if the output is full):
// the bit-serial divider produces one quotient bit per cycle.
// The result sits in an output register, so the next word is taken while it waits.
// Reset is synchronous; the row-sum RAM is not cleared and needs no pass.
module trace_group_average_decimator #(
   parameter int MAX_ROWS = tgad_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_STEP = tgad_pkg::MAX_STEP_DEFAULT,
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tgad_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_block_end,
   // result words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tgad_pkg::SAMPLE_W-1:0] rsp_average,
   output logic [ROW_W-1:0]                     rsp_row_index,
   output logic                                 rsp_last_row,
   // CSR port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tgad_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tgad_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tgad_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import tgad_pkg::*;

   // count width holds MAX_STEP itself; sums of MAX_STEP samples need clog2(MAX_STEP)
   // bits of growth
   localparam int CNT_W  = $clog2(MAX_STEP + 1);
   localparam int SUM_W  = SAMPLE_W + $clog2(MAX_STEP);
   localparam int RLIM_W = $clog2(MAX_ROWS + 1);
   localparam int RCMP_W = (RLIM_W > ROWS_CFG_W) ? RLIM_W : ROWS_CFG_W;
   localparam int SCMP_W = (CNT_W > STEP_CFG_W) ? CNT_W : STEP_CFG_W;

   //---------------------------------------------------------------------------
   // CSRs
   //---------------------------------------------------------------------------
   logic [ROWS_CFG_W-1:0] rows_cfg_ff, rows_cfg_in;
   logic [STEP_CFG_W-1:0] step_cfg_ff, step_cfg_in;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rows_cfg_in = rows_cfg_ff;
      step_cfg_in = step_cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[CSR_IDX_LSB])
            REG_ROWS_PER_TRACE: rows_cfg_in = csr_pwdata[ROWS_CFG_W-1:0];
            REG_GROUP_STEP:     step_cfg_in = csr_pwdata[STEP_CFG_W-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_IDX_LSB])
         REG_ROWS_PER_TRACE: csr_prdata = CSR_DATA_W'(rows_cfg_ff);
         REG_GROUP_STEP:     csr_prdata = CSR_DATA_W'(step_cfg_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // effective limits: zero reads as one, oversize clamps to the maximum
   logic [RCMP_W-1:0] rows_eff;
   logic [SCMP_W-1:0] step_eff;

   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_eff = RCMP_W'(1);
      end else if (RCMP_W'(rows_cfg_ff) > RCMP_W'(MAX_ROWS)) begin
         rows_eff = RCMP_W'(MAX_ROWS);
      end else begin
         rows_eff = RCMP_W'(rows_cfg_ff);
      end
      if (step_cfg_ff == '0) begin
         step_eff = SCMP_W'(1);
      end else if (SCMP_W'(step_cfg_ff) > SCMP_W'(MAX_STEP)) begin
         step_eff = SCMP_W'(MAX_STEP);
      end else begin
         step_eff = SCMP_W'(step_cfg_ff);
      end
   end

   //---------------------------------------------------------------------------
   // Datapath state
   //---------------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [ROW_W-1:0]           row_pos_ff, row_pos_in;
   logic [CNT_W-1:0]           traces_ff, traces_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       bend_ff;
   logic [ROW_W-1:0]           pend_row_ff;
   logic                       pend_last_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff;
   logic [ROW_W-1:0]           rsp_row_ff;
   logic                       rsp_last_ff;

   // control from the sequencer
   logic accept, ram_wr, div_start, rsp_load;

   // RAM and divider hookup
   logic signed [SUM_W-1:0]    rd_sum;
   logic signed [SUM_W-1:0]    new_sum;
   logic signed [SAMPLE_W-1:0] div_quo;
   logic                       div_done;

   // READ-stage decisions
   logic              is_last;
   logic [SCMP_W-1:0] count;
   logic              close;
   logic              rsp_free;

   assign is_last  = (RCMP_W'(row_pos_ff) + RCMP_W'(1)) >= rows_eff;
   assign count    = SCMP_W'(traces_ff) + SCMP_W'(1);
   assign close    = bend_ff || (count >= step_eff);
   // first trace of a group loads the sum instead of adding
   assign new_sum  = (traces_ff == '0) ? SUM_W'(sample_ff) : rd_sum + SUM_W'(sample_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   //---------------------------------------------------------------------------
   // Sequencer
   //---------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      accept    = 1'b0;
      ram_wr    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            ram_wr    = 1'b1;
            div_start = close;
            state_in  = close ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            // divider keeps its quotient until the next start
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // row position advances once per word, in READ; the group count only on the last row
   always_comb begin
      row_pos_in = row_pos_ff;
      traces_in  = traces_ff;
      if (ram_wr) begin
         if (is_last) begin
            row_pos_in = '0;
            traces_in  = close ? '0 : CNT_W'(count);
         end else begin
            row_pos_in = row_pos_ff + ROW_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_cfg_ff  <= ROWS_RESET;
         step_cfg_ff  <= STEP_RESET;
         row_pos_ff   <= '0;
         traces_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_cfg_ff  <= rows_cfg_in;
         step_cfg_ff  <= step_cfg_in;
         row_pos_ff   <= row_pos_in;
         traces_ff    <= traces_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         bend_ff   <= req_block_end;
      end
      if (ram_wr) begin
         pend_row_ff  <= row_pos_ff;
         pend_last_ff <= is_last;
      end
      if (rsp_load) begin
         rsp_average_ff <= div_quo;
         rsp_row_ff     <= pend_row_ff;
         rsp_last_ff    <= pend_last_ff;
      end
   end

   //---------------------------------------------------------------------------
   // Row-sum RAM and divider
   //---------------------------------------------------------------------------
   tgad_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_ROWS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (row_pos_ff),
      .wr_data (new_sum),
      .rd_en   (accept),
      .rd_addr (row_pos_ff),
      .rd_data (rd_sum)
   );

   tgad_div #(
      .SUM_W (SUM_W),
      .DIV_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_sum),
      .divisor  (CNT_W'(count)),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_average   = rsp_average_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_last_row  = rsp_last_ff;

`ifndef SYNTHESIS
   // one word in flight: no second word right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("word accepted while another is in flight");

   // the divider only finishes while the sequencer waits on it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // a new result only follows a divide
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DIV || $past(state_ff) == ST_HOLD))
      else $error("result raised without a divide");

   // the group count never reaches the effective step after the last row
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (ram_wr && is_last && !close) |=> (SCMP_W'(traces_ff) < step_eff))
      else $error("group count left at or past the step");
`endif

endmodule

/* tb/tb_trace_group_average_decimator.sv */
// Self-checking testbench for the trace group average decimator.
module tb_trace_group_average_decimator;
   import tgad_pkg::*;

   localparam int MAX_ROWS       = MAX_ROWS_DEFAULT;
   localparam int MAX_STEP       = MAX_STEP_DEFAULT;
   localparam int ROW_W          = $clog2(MAX_ROWS);
   localparam int TOTAL_WORDS    = 1150;
   localparam int SETTLE_CYCLES  = 48;    // longer than the divider worst case
   localparam int PRESSURE_HOLD  = 400;
   localparam int WATCHDOG_LIMIT = 2000;

   // directed table: a word to send or a register write
   typedef enum logic [1:0] {ROW_WORD, ROW_SET_ROWS, ROW_SET_STEP} dir_kind_type;
   // how a word is checked: predictor, no result, or the result typed in the table
   typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} dir_exp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic [ROW_W-1:0]    row_index;
      logic                last_row;
   } avg_word_type;

   typedef struct packed {
      dir_kind_type        kind;
      logic [31:0]         value;
      logic                block_end;
      dir_exp_type         check;
      logic [SAMPLE_W-1:0] avg;
      logic [ROW_W-1:0]    row;
      logic                last;
   } dir_row_type;

   localparam int DIR_COUNT = 32;
   localparam dir_row_type DIR_TAB [DIR_COUNT] = '{
      // reset config: one row, pairs of traces; extremes average to themselves
      '{ROW_WORD,     32'h7FFF_FFFF, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h7FFF_FFFF, 1'b0, EXP_GIVEN, 32'h7FFF_FFFF, 10'd0, 1'b1},
      // block end cuts a group after one trace
      '{ROW_WORD,     32'h8000_0000, 1'b1, EXP_GIVEN, 32'h8000_0000, 10'd0, 1'b1},
      '{ROW_WORD,     32'h8000_0000, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h8000_0000, 1'b0, EXP_GIVEN, 32'h8000_0000, 10'd0, 1'b1},
      // truncation toward zero, both signs
      '{ROW_WORD,     32'hFFFF_FFFD, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0000, 1'b0, EXP_GIVEN, 32'hFFFF_FFFF, 10'd0, 1'b1},
      '{ROW_WORD,     32'h0000_0003, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0000, 1'b0, EXP_GIVEN, 32'h0000_0001, 10'd0, 1'b1},
      // zero step acts as one
      '{ROW_SET_STEP, 32'd0,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0005, 1'b0, EXP_GIVEN, 32'h0000_0005, 10'd0, 1'b1},
      // zero rows acts as one; step above max, group closed early by block end
      '{ROW_SET_ROWS, 32'd0,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_SET_STEP, 32'd31,        1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0001, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0002, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0003, 1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'h0000_0004, 1'b1, EXP_GIVEN, 32'h0000_0002, 10'd0, 1'b1},
      // three rows: row index and last row flag
      '{ROW_SET_ROWS, 32'd3,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_SET_STEP, 32'd2,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd10,        1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd20,        1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd30,        1'b0, EXP_NONE,  32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd11,        1'b0, EXP_GIVEN, 32'd10,        10'd0, 1'b0},
      '{ROW_WORD,     32'd21,        1'b0, EXP_GIVEN, 32'd20,        10'd1, 1'b0},
      '{ROW_WORD,     32'd31,        1'b0, EXP_GIVEN, 32'd30,        10'd2, 1'b1},
      // block end changing inside a trace; last row decides the group count
      '{ROW_SET_STEP, 32'd3,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd100,       1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd200,       1'b1, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd300,       1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd7,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd8,         1'b0, EXP_MODEL, 32'h0,         10'd0, 1'b0},
      '{ROW_WORD,     32'd9,         1'b1, EXP_MODEL, 32'h0,         10'd0, 1'b0}
   };

   // DUT ports; every input known from time zero
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample    = '0;
   logic                  req_block_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_average;
   logic [ROW_W-1:0]      rsp_row_index;
   logic                  rsp_last_row;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state: config copy, per-row sums, row and group counters
   logic [ROWS_CFG_W-1:0]   cfg_rows      = ROWS_RESET;
   logic [STEP_CFG_W-1:0]   cfg_step      = STEP_RESET;
   logic signed [35:0]      sum_by_row [MAX_ROWS];
   logic [ROW_W-1:0]        row_cursor    = '0;
   logic [4:0]              traces_summed = '0;
   int                      rows_touched  = 0;   // rows 0..n-1 hold a written sum
   int                      widest_group  = 0;

   avg_word_type expected_averages [$];

   // how the word on the bus right now is checked (set by the driver with the payload)
   dir_exp_type  word_check = EXP_MODEL;
   avg_word_type word_given = '0;

   int  errors           = 0;
   int  words_sent       = 0;
   int  dir_words        = 0;
   int  averages_checked = 0;
   int  reg_writes       = 0;
   bit  backpressure_seen = 1'b0;

   trace_group_average_decimator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_average   (rsp_average),
      .rsp_row_index (rsp_row_index),
      .rsp_last_row  (rsp_last_row),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #6 clock = ~clock;

   // register value as the datapath sees it: zero means one, clamp to the max
   function automatic int eff_rows(input logic [ROWS_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_ROWS) return MAX_ROWS;
      return int'(v);
   endfunction

   function automatic int eff_step(input logic [STEP_CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_STEP) return MAX_STEP;
      return int'(v);
   endfunction

   // Accumulate one word into its row and work out the average it releases, if any.
   function automatic void predict_average(input logic [SAMPLE_W-1:0] smp, input logic bend,
                                           output logic has_avg, output avg_word_type avg_out);
      int rows, step, r, count;
      logic is_last;
      logic signed [35:0] sum;
      longint quo;
      rows = eff_rows(cfg_rows);
      step = eff_step(cfg_step);
      r = int'(row_cursor);
      // a cursor at or past a shrunken row count ends the trace here
      is_last = (r + 1 >= rows);
      sum = {{4{smp[SAMPLE_W-1]}}, smp};
      // first trace of a group loads the sum, later traces add
      if (traces_summed != 0) sum = sum + sum_by_row[r];
      sum_by_row[r] = sum;
      if (r + 1 > rows_touched) rows_touched = r + 1;
      count = int'(traces_summed) + 1;
      has_avg = bend || (count >= step);
      if (has_avg && count > widest_group) widest_group = count;
      quo = longint'(sum) / count;   // truncates toward zero
      avg_out.average   = quo[SAMPLE_W-1:0];
      avg_out.row_index = r[ROW_W-1:0];
      avg_out.last_row  = is_last;
      // group count follows the block end of the last row only
      if (is_last) begin
         row_cursor    = '0;
         traces_summed = has_avg ? 5'd0 : 5'(count);
      end else begin
         row_cursor = ROW_W'(r + 1);
      end
   endfunction

   // Scoreboard: check delivered averages, then predict from the accepted word.
   always @(posedge clock) begin : scoreboard
      avg_word_type want, got;
      logic has;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_average, rsp_row_index, rsp_last_row};
         if (expected_averages.size() == 0) begin
            $display("%0t: unexpected word avg=%h row=%0d last=%b", $time,
                     got.average, got.row_index, got.last_row);
            errors++;
         end else begin
            want = expected_averages.pop_front();
            averages_checked++;
            if (got.average !== want.average) begin
               $display("%0t: average expected %h got %h", $time, want.average, got.average);
               errors++;
            end
            if (got.row_index !== want.row_index) begin
               $display("%0t: row_index expected %0d got %0d", $time,
                        want.row_index, got.row_index);
               errors++;
            end
            if (got.last_row !== want.last_row) begin
               $display("%0t: last_row expected %b got %b", $time, want.last_row, got.last_row);
               errors++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         predict_average(req_sample, req_block_end, has, want);
         // table rows with no result or a typed result override the predictor
         if (word_check == EXP_NONE) begin
            has = 1'b0;
         end else if (word_check == EXP_GIVEN) begin
            has  = 1'b1;
            want = word_given;
         end
         if (has) expected_averages = {expected_averages, want};
      end
   end

   // Watchdog: stop on a long run of cycles with no handshake on any port.
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d averages outstanding", $time,
                  quiet, expected_averages.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Receiver: random stalls, some free-running stretches, and one long hold while
   // the sender keeps pushing so the block backs up into req_ready.
   initial begin : receiver
      int stall_left, free_left, hold_left, pick;
      stall_left = 0;
      free_left  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!backpressure_seen && rsp_valid && req_valid && averages_checked > 30) begin
            backpressure_seen = 1'b1;
            hold_left = PRESSURE_HOLD - 1;
            rsp_ready <= 1'b0;
         end else if (free_left > 0) begin
            rsp_ready <= 1'b1;
            free_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               free_left = $urandom_range(50, 200);
               rsp_ready <= 1'b1;
            end else if (pick < 23) begin
               stall_left = $urandom_range(0, 2);
               rsp_ready <= 1'b0;
            end else if (pick < 26) begin
               stall_left = $urandom_range(5, 40);
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // hard mode leans on the rails so sums hit the 36-bit extremes
   function automatic logic [SAMPLE_W-1:0] pick_sample(input bit hard);
      int pick;
      pick = $urandom_range(0, hard ? 3 : 11);
      case (pick)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return hard ? 32'h8000_0001 : 32'h0;
         4:       return 32'($urandom_range(0, 16)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ROWS_CFG_W-1:0] pick_rows();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return 11'd2047;
         2:       return 11'd1024;
         3:       return 11'($urandom_range(1025, 2046));
         4, 5:    return 11'($urandom_range(9, 64));
         default: return 11'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [STEP_CFG_W-1:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 5'd31;
         2:       return 5'd16;
         3:       return 5'($urandom_range(17, 30));
         default: return 5'($urandom_range(1, 8));
      endcase
   endfunction

   // Offer one word and hold it until taken. Entered and left just after a falling edge.
   task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic bend,
                            input bit gapless, input dir_exp_type chk,
                            input avg_word_type given);
      int gap;
      gap = gapless ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      word_check = chk;
      word_given = given;
      req_valid     <= 1'b1;
      req_sample    <= smp;
      req_block_end <= bend;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   // Drop valid, let every expected average drain, then cover a divide still in flight.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic csr_write(input logic idx, input logic [CSR_DATA_W-1:0] data);
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] want;
      addr = '0;
      addr[CSR_IDX_LSB] = idx;
      if (idx == REG_ROWS_PER_TRACE) begin
         cfg_rows = data[ROWS_CFG_W-1:0];
         want = CSR_DATA_W'(cfg_rows);
      end else begin
         cfg_step = data[STEP_CFG_W-1:0];
         want = CSR_DATA_W'(cfg_step);
      end
      reg_writes++;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         $display("%0t: csr read of reg %0d expected %h got %h", $time, idx, want, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // return to idle between transfers
      @(negedge clock);
   endtask

   initial begin : stimulus
      int i, len, rows, step, pos, be_rate, random_words;
      bit gapless, hard, trace_end, big_done, wr_rows, wr_step;
      logic bend;
      logic [ROWS_CFG_W-1:0] new_rows;

      random_words = 0;
      big_done     = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed table ----
      for (i = 0; i < DIR_COUNT; i++) begin
         case (DIR_TAB[i].kind)
            ROW_SET_ROWS: begin
               settle();
               csr_write(REG_ROWS_PER_TRACE, DIR_TAB[i].value);
            end
            ROW_SET_STEP: begin
               settle();
               csr_write(REG_GROUP_STEP, DIR_TAB[i].value);
            end
            default: begin
               send_word(DIR_TAB[i].value, DIR_TAB[i].block_end, 1'b0, DIR_TAB[i].check,
                         '{DIR_TAB[i].avg, DIR_TAB[i].row, DIR_TAB[i].last});
               dir_words++;
            end
         endcase
      end

      // ---- random phases, config changed between them ----
      // Phases stop at arbitrary points, so config often changes mid-trace and
      // mid-group. Rows only grow past the written range while no group is open.
      while (words_sent < TOTAL_WORDS) begin
         settle();

         // one full trace at the largest row count, one average per word
         if (!big_done) begin
            while (traces_summed != 0 || row_cursor != 0)
               send_word(pick_sample(1'b0), 1'b1, 1'b0, EXP_MODEL, '0);
            settle();
            csr_write(REG_ROWS_PER_TRACE, 32'd1024);
            csr_write(REG_GROUP_STEP, 32'd1);
            repeat (MAX_ROWS) send_word(pick_sample(1'b0), 1'($urandom), 1'b1, EXP_MODEL, '0);
            big_done = 1'b1;
            settle();
         end

         new_rows = pick_rows();
         wr_rows  = ($urandom_range(0, 9) < 7);
         wr_step  = ($urandom_range(0, 9) < 7) || !wr_rows;
         if (traces_summed != 0 && eff_rows(new_rows) > rows_touched) begin
            new_rows = ROWS_CFG_W'(rows_touched);
         end
         // upper bits carry junk half the time; the register keeps only its width
         if (wr_rows)
            csr_write(REG_ROWS_PER_TRACE, $urandom_range(0, 1) ?
                      (($urandom & ~32'h7FF) | CSR_DATA_W'(new_rows)) : CSR_DATA_W'(new_rows));
         if (wr_step)
            csr_write(REG_GROUP_STEP, CSR_DATA_W'(pick_step()));

         rows = eff_rows(cfg_rows);
         step = eff_step(cfg_step);
         len  = rows * $urandom_range(1, 2 * step + 1) + $urandom_range(0, rows - 1);
         if (len > 150) len = $urandom_range(20, 150);
         gapless = ($urandom_range(0, 3) == 0);
         hard    = ($urandom_range(0, 3) == 0);
         be_rate = ($urandom_range(0, 2) == 0) ? 0 : 10;

         // block_end is held for a whole trace; a few words flip it as noise
         pos = int'(row_cursor);
         trace_end = (be_rate != 0) && ($urandom_range(1, be_rate) == 1);
         for (i = 0; i < len; i++) begin
            bend = trace_end;
            if ($urandom_range(0, 19) == 0) bend = ~bend;
            send_word(pick_sample(hard), bend, gapless, EXP_MODEL, '0);
            random_words++;
            if (pos + 1 >= rows) begin
               pos = 0;
               trace_end = (be_rate != 0) && ($urandom_range(1, be_rate) == 1);
            end else begin
               pos++;
            end
         end
      end

      settle();
      $display("covered %0d words (%0d directed, %0d random), %0d averages checked, %0d register writes",
               words_sent, dir_words, random_words, averages_checked, reg_writes);
      $display("widest group %0d traces, %0d rows reached, output hold-off %s",
               widest_group, rows_touched, backpressure_seen ? "applied" : "not reached");
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
